// ===== rtl/core/gdk_pkg.sv =====
// gdk_pkg: shared types and constants of the group dominant key detector
// no dependencies; imported by the interfaces, the register block and the top level
`default_nettype none

package gdk_pkg;

  // fixed field widths of the words on the channels
  localparam int KEY_W  = 16;
  localparam int SITE_W = 31;
  localparam int END_W  = 32;
  localparam int SIZE_W = 9;
  localparam int FLANK_W = 16;
  localparam int THR_W  = 16;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd655;
  localparam logic [FLANK_W-1:0] FLANK_RESET = 16'd50;

  typedef enum logic [0:0] {
    REG_SHARE_THRESHOLD = 1'b0,
    REG_FLANK_LENGTH    = 1'b1
  } gdk_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]   share_threshold;
    logic [FLANK_W-1:0] flank_length;
  } gdk_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/gdk_if.sv =====
// gdk_if: valid/ready channel interfaces for input and result words
// depends on gdk_pkg for the field widths
`default_nettype none

interface gdk_in_if
  import gdk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  target_key;
  logic [SITE_W-1:0] site_position;
  logic              group_end;

  modport source (output valid, target_key, site_position, group_end, input ready);
  modport sink   (input valid, target_key, site_position, group_end, output ready);
endinterface

interface gdk_out_if
  import gdk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              assigned;
  logic [KEY_W-1:0]  dominant_key;
  logic [SITE_W-1:0] window_start;
  logic [END_W-1:0]  window_end;
  logic [SIZE_W-1:0] group_size;
  logic              overflow;

  modport source (output valid, assigned, dominant_key, window_start, window_end,
                  group_size, overflow, input ready);
  modport sink   (input valid, assigned, dominant_key, window_start, window_end,
                  group_size, overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdk_cfg_regs.sv =====
// gdk_cfg_regs: apb-style register block holding threshold and flank length
// depends on gdk_pkg
`default_nettype none

module gdk_cfg_regs
  import gdk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output gdk_cfg_t               cfg
);

  gdk_cfg_t cfg_r;
  gdk_cfg_t cfg_nxt;
  gdk_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = gdk_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_SHARE_THRESHOLD: cfg_nxt.share_threshold = pwdata[THR_W-1:0];
        REG_FLANK_LENGTH:    cfg_nxt.flank_length    = pwdata[FLANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SHARE_THRESHOLD: prdata = CFG_DW'(cfg_r.share_threshold);
      REG_FLANK_LENGTH:    prdata = CFG_DW'(cfg_r.flank_length);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.share_threshold <= THR_RESET;
      cfg_r.flank_length    <= FLANK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdk_entry_mem.sv =====
// gdk_entry_mem: key/count table, one write and one registered read port
// no package dependency
`default_nettype none

module gdk_entry_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 25
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/group_dominant_key_detect.sv =====
// group_dominant_key_detect: top level with the scan sequencer and result register
// depends on gdk_pkg, gdk_if, gdk_cfg_regs and gdk_entry_mem
`default_nettype none

// Counts the keys of one group of alignments (one word per alignment, the
// last one flagged by group_end) in a table of MAX_KEYS key/count entries and,
// on the last word, reports whether exactly one key holds a share of the group
// strictly above share_threshold/65536, that key, and the flank window
// [site - flank_length clamped at 0, site + flank_length] around the site of
// the group's first word. Each input word scans the table through the single
// read port of the entry memory, one entry per cycle, over the d distinct keys
// held when it arrives (at most MAX_KEYS); a word dropped from a full group
// does not scan. A closing word adds a multiply step, a second pass over the
// table and an output step, plus any wait for the result register to free up.
// in ready is high only while the sequencer is idle; a finished result sits in
// the output register and the next word is taken while it waits. More than
// MAX_GROUP words or more than MAX_KEYS distinct keys in a group raises
// overflow and clears assigned. Configuration registers: share_threshold at
// byte address 0 (reset 655) and flank_length at 4 (reset 50).

module group_dominant_key_detect
  import gdk_pkg::*;
#(
  parameter int MAX_KEYS  = 64,
  parameter int MAX_GROUP = 256,
  parameter int KEY_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gdk_in_if.sink                 in_ch,
  gdk_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  // stored key width: keys are masked to KEY_BITS, never wider than the field
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int EW = KW + CW;
  localparam int PW = THR_W + CW;
  localparam logic [CW-1:0] GROUP_LIMIT = CW'(MAX_GROUP);
  localparam logic [NW-1:0] KEY_LIMIT   = NW'(MAX_KEYS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_EVAL = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  gdk_cfg_t cfg;

  // sequencer and group state
  state_t          state_r, state_nxt;
  logic            in_group_r, in_group_nxt;
  logic            ovf_r, ovf_nxt;
  logic [NW-1:0]   distinct_r, distinct_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [SITE_W-1:0] site_r, site_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic            last_r, last_nxt;

  // table walk
  logic [NW-1:0]   idx_r, idx_nxt;
  logic            pend_r, pend_nxt;
  logic [IW-1:0]   pend_idx_r, pend_idx_nxt;

  // end-of-group evaluation
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [1:0]      n_above_r, n_above_nxt;
  logic [KW-1:0]   winner_r, winner_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              res_assigned_r, res_assigned_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [SITE_W-1:0] res_start_r, res_start_nxt;
  logic [END_W-1:0]  res_end_r, res_end_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;
  logic              res_ovf_r, res_ovf_nxt;

  // entry memory port
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;
  logic [KW-1:0]   rd_key;
  logic [CW-1:0]   rd_cnt;
  logic            issue;
  logic            accept;

  gdk_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gdk_entry_mem #(
    .DEPTH (MAX_KEYS),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key = mem_rdata[EW-1:CW];
  assign rd_cnt = mem_rdata[CW-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);

  // the walk issues one table read per cycle while entries remain
  assign issue     = (idx_r < distinct_r);
  assign mem_raddr = idx_r[IW-1:0];

  assign out_ch.valid        = out_valid_r;
  assign out_ch.assigned     = res_assigned_r;
  assign out_ch.dominant_key = res_key_r;
  assign out_ch.window_start = res_start_r;
  assign out_ch.window_end   = res_end_r;
  assign out_ch.group_size   = res_size_r;
  assign out_ch.overflow     = res_ovf_r;

  always_comb begin
    state_nxt    = state_r;
    in_group_nxt = in_group_r;
    ovf_nxt      = ovf_r;
    distinct_nxt = distinct_r;
    total_nxt    = total_r;
    site_nxt     = site_r;
    key_nxt      = key_r;
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    prod_nxt     = prod_r;
    n_above_nxt  = n_above_r;
    winner_nxt   = winner_r;

    out_valid_nxt    = out_valid_r && !out_ch.ready;
    res_assigned_nxt = res_assigned_r;
    res_key_nxt      = res_key_r;
    res_start_nxt    = res_start_r;
    res_end_nxt      = res_end_r;
    res_size_nxt     = res_size_r;
    res_ovf_nxt      = res_ovf_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt  = in_ch.target_key[KW-1:0];
          last_nxt = in_ch.group_end;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          // first word of a group restarts the tables and latches the site
          if (!in_group_r) begin
            distinct_nxt = '0;
            total_nxt    = '0;
            ovf_nxt      = 1'b0;
            site_nxt     = in_ch.site_position;
            in_group_nxt = 1'b1;
          end
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (total_r >= GROUP_LIMIT) begin
          // group already full: word is dropped
          ovf_nxt   = 1'b1;
          state_nxt = last_r ? S_MUL : S_IDLE;
        end else if (pend_r && rd_key == key_r) begin
          // hit: bump the count in place
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r;
          mem_wdata = {key_r, rd_cnt + CW'(1)};
          total_nxt = total_r + CW'(1);
          state_nxt = last_r ? S_MUL : S_IDLE;
        end else if (issue) begin
          mem_re       = 1'b1;
          idx_nxt      = idx_r + NW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IW-1:0];
        end else begin
          // miss over the whole table: append or flag overflow
          if (distinct_r < KEY_LIMIT) begin
            mem_we       = 1'b1;
            mem_waddr    = distinct_r[IW-1:0];
            mem_wdata    = {key_r, CW'(1)};
            distinct_nxt = distinct_r + NW'(1);
            total_nxt    = total_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = last_r ? S_MUL : S_IDLE;
        end
      end

      S_MUL: begin
        // threshold times total, shared by every entry of the second pass
        prod_nxt    = PW'(cfg.share_threshold) * PW'(total_r);
        n_above_nxt = '0;
        winner_nxt  = '0;
        idx_nxt     = '0;
        pend_nxt    = 1'b0;
        state_nxt   = S_EVAL;
      end

      S_EVAL: begin
        if (pend_r && ({rd_cnt, THR_W'(0)} > prod_r)) begin
          winner_nxt = rd_key;
          if (n_above_r != 2'd2) begin
            n_above_nxt = n_above_r + 2'd1;
          end
        end
        if (issue) begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + NW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          res_assigned_nxt = (n_above_r == 2'd1) && !ovf_r;
          res_key_nxt      = ((n_above_r == 2'd1) && !ovf_r) ? KEY_W'(winner_r) : '0;
          res_start_nxt    = (site_r > SITE_W'(cfg.flank_length))
                             ? site_r - SITE_W'(cfg.flank_length) : '0;
          res_end_nxt      = END_W'(site_r) + END_W'(cfg.flank_length);
          res_size_nxt     = SIZE_W'(total_r);
          res_ovf_nxt      = ovf_r;
          in_group_nxt     = 1'b0;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_group_r  <= 1'b0;
      ovf_r       <= 1'b0;
      distinct_r  <= '0;
      total_r     <= '0;
      site_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      n_above_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_group_r  <= in_group_nxt;
      ovf_r       <= ovf_nxt;
      distinct_r  <= distinct_nxt;
      total_r     <= total_nxt;
      site_r      <= site_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      n_above_r   <= n_above_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    last_r         <= last_nxt;
    pend_idx_r     <= pend_idx_nxt;
    prod_r         <= prod_nxt;
    winner_r       <= winner_nxt;
    res_assigned_r <= res_assigned_nxt;
    res_key_r      <= res_key_nxt;
    res_start_r    <= res_start_nxt;
    res_end_r      <= res_end_nxt;
    res_size_r     <= res_size_nxt;
    res_ovf_r      <= res_ovf_nxt;
  end

endmodule

`default_nettype wire

// ===== dv/tb_group_dominant_key_detect.sv =====
// tb_group_dominant_key_detect: self-checking testbench of the group dominant key detector
// depends on gdk_pkg, gdk_if (gdk_in_if, gdk_out_if) and the group_dominant_key_detect rtl
// drives alignment words and register writes, predicts each call and checks it field by field

module tb_group_dominant_key_detect;
  import gdk_pkg::*;

  // sizes the dut is built with, mirrored by the predictor
  localparam int MAX_KEYS  = 64;
  localparam int MAX_GROUP = 256;
  localparam int KEY_BITS  = 16;

  // run shape
  localparam int RANDOM_WORDS  = 720;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 200;      // two full table scans plus margin
  localparam int HOLD_CYCLES   = 3000;     // long receiver hold-off
  localparam int TIMEOUT_NS    = 8_000_000;

  // one dominant key call as it leaves the block
  typedef struct {
    logic              assigned;
    logic [KEY_W-1:0]  dominant_key;
    logic [SITE_W-1:0] window_start;
    logic [END_W-1:0]  window_end;
    logic [SIZE_W-1:0] group_size;
    logic              overflow;
  } key_call_t;

  // receiver behavior, switched every so often
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  // register port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  gdk_in_if  in_bus ();
  gdk_out_if out_bus ();

  group_dominant_key_detect #(
    .MAX_KEYS (MAX_KEYS),
    .MAX_GROUP(MAX_GROUP),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 8 time unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: key/count table of the open group plus the register copy
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]  seen_key [MAX_KEYS];
  int unsigned       seen_count [MAX_KEYS];
  int unsigned       keys_used      = 0;
  int unsigned       aligned_total  = 0;
  logic [SITE_W-1:0] group_site     = '0;
  logic              group_open     = 1'b0;
  logic              group_overflow = 1'b0;
  logic [THR_W-1:0]  thr_cfg        = THR_RESET;
  logic [FLANK_W-1:0] flank_cfg     = FLANK_RESET;

  // calls still owed by the block, oldest first
  key_call_t expected_calls[$];

  int mismatch_count = 0;
  int words_sent     = 0;

  // sender burst bookkeeping
  int burst_left    = 0;
  bit steady_sender = 1'b0;

  // keys of the next group to send
  logic [KEY_W-1:0] group_keys[$];

  // receiver stall state, owned by the receiver process
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          mode_left     = 0;
  stall_mode_t stall_mode    = STALL_NONE;
  logic [7:0]  stall_pattern = 8'hFF;

  // count one alignment and, on the group's last word, queue the call it makes
  task automatic tally_alignment(input logic [KEY_W-1:0] key, input logic [SITE_W-1:0] site,
                                 input logic last);
    int unsigned       idx;
    int unsigned       passing;
    logic              found;
    logic [KEY_W-1:0]  winner;
    longint unsigned   share_lhs;
    longint unsigned   share_rhs;
    key_call_t         call;
    // first word of a group opens it and latches the site
    if (!group_open) begin
      keys_used      = 0;
      aligned_total  = 0;
      group_overflow = 1'b0;
      group_site     = site;
      group_open     = 1'b1;
    end
    if (aligned_total >= MAX_GROUP) begin
      // word beyond the group limit is dropped
      group_overflow = 1'b1;
    end else begin
      found = 1'b0;
      for (idx = 0; idx < keys_used; idx++) begin
        if (!found && seen_key[idx] == key) begin
          seen_count[idx]++;
          found = 1'b1;
        end
      end
      if (found) begin
        aligned_total++;
      end else if (keys_used < MAX_KEYS) begin
        seen_key[keys_used]   = key;
        seen_count[keys_used] = 1;
        keys_used++;
        aligned_total++;
      end else begin
        // new key with a full table is dropped
        group_overflow = 1'b1;
      end
    end
    if (last) begin
      passing = 0;
      winner  = '0;
      // share strictly above threshold/65536, done in integers
      for (idx = 0; idx < keys_used; idx++) begin
        share_lhs = longint'(seen_count[idx]) << 16;
        share_rhs = longint'(thr_cfg) * longint'(aligned_total);
        if (share_lhs > share_rhs) begin
          passing++;
          winner = seen_key[idx];
        end
      end
      call.assigned     = (passing == 1) && !group_overflow;
      call.dominant_key = call.assigned ? winner : '0;
      call.window_start = (group_site > SITE_W'(flank_cfg)) ? group_site - SITE_W'(flank_cfg) : '0;
      call.window_end   = {1'b0, group_site} + END_W'(flank_cfg);
      call.group_size   = SIZE_W'(aligned_total);
      call.overflow     = group_overflow;
      expected_calls.push_back(call);
      group_open = 1'b0;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    // a test may ask for a long hold-off; it is counted down here
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode    = stall_mode_t'($urandom_range(0, 3));
        mode_left     = $urandom_range(16, 300);
        stall_pattern = 8'($urandom);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_bus.ready <= 1'b1;
        STALL_COIN:  out_bus.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY: out_bus.ready <= ($urandom_range(0, 4) == 0);
        default:     out_bus.ready <= stall_pattern[mode_left % 8];
      endcase
    end
  end

  // each call the block hands over is matched against the oldest expectation
  always @(posedge clk) begin
    key_call_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_calls.size() == 0) begin
        $display("%0t: unexpected word, expected none, got assigned=%0d key=0x%0h size=%0d",
                 $time, out_bus.assigned, out_bus.dominant_key, out_bus.group_size);
        mismatch_count++;
      end else begin
        want = expected_calls.pop_front();
        check_field("assigned", 32'(want.assigned), 32'(out_bus.assigned));
        check_field("dominant_key", 32'(want.dominant_key), 32'(out_bus.dominant_key));
        check_field("window_start", 32'(want.window_start), 32'(out_bus.window_start));
        check_field("window_end", want.window_end, out_bus.window_end);
        check_field("group_size", 32'(want.group_size), 32'(out_bus.group_size));
        check_field("overflow", 32'(want.overflow), 32'(out_bus.overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // offer one word, holding valid until it is taken
  task automatic send_word(input logic [KEY_W-1:0] key, input logic [SITE_W-1:0] site,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.target_key    <= key;
    in_bus.site_position <= site;
    in_bus.group_end     <= last;
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
    tally_alignment(key, site, last);
    @(negedge clk);
  endtask

  // sender pause until every call is in, then let the block settle
  task automatic drain_calls();
    in_bus.valid <= 1'b0;
    while (expected_calls.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register transfer: setup cycle, then access until pready
  task automatic reg_transfer(input logic wr, input gdk_reg_t idx, input logic [CFG_DW-1:0] wdata,
                              output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_check(input gdk_reg_t idx, input logic [15:0] want);
    logic [CFG_DW-1:0] rdata;
    reg_transfer(1'b0, idx, '0, rdata);
    check_field(idx.name(), 32'(want), 32'(rdata[15:0]));
  endtask

  // write a register, keep the predictor's copy in step and read it back
  task automatic write_reg(input gdk_reg_t idx, input logic [15:0] value);
    logic [CFG_DW-1:0] rdata;
    reg_transfer(1'b1, idx, CFG_DW'(value), rdata);
    case (idx)
      REG_SHARE_THRESHOLD: thr_cfg   = value;
      REG_FLANK_LENGTH:    flank_cfg = value;
      default: ;
    endcase
    read_check(idx, value);
  endtask

  // registers change only with the block idle
  task automatic set_config(input logic [THR_W-1:0] thr, input logic [FLANK_W-1:0] flank);
    drain_calls();
    write_reg(REG_SHARE_THRESHOLD, thr);
    write_reg(REG_FLANK_LENGTH, flank);
  endtask

  function automatic logic [SITE_W-1:0] rand_site();
    case ($urandom_range(0, 3))
      0:       return SITE_W'($urandom_range(0, 200));                // near zero, clamps
      1:       return 31'h7FFF_FFFF - SITE_W'($urandom_range(0, 70000)); // near the top
      default: return SITE_W'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 15));
      1:       return 16'hFFFF - KEY_W'($urandom_range(0, 15));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // send group_keys as one group; later sites differ so the latch is exercised
  task automatic send_group_keys(input logic [SITE_W-1:0] site);
    int idx;
    for (idx = 0; idx < group_keys.size(); idx++) begin
      send_word(group_keys[idx], (idx == 0) ? site : rand_site(), idx == group_keys.size() - 1);
    end
  endtask

  // random group: mostly short with a few keys, now and then long and wide
  task automatic send_random_group();
    int len;
    int n_keys;
    int dom_pct;
    int pick;
    int idx;
    logic [KEY_W-1:0] palette [96];
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      len    = $urandom_range(1, 6);
      n_keys = $urandom_range(1, 3);
    end else if (pick < 90) begin
      len    = $urandom_range(7, 30);
      n_keys = $urandom_range(1, 5);
    end else if (pick < 98) begin
      len    = $urandom_range(31, 90);
      n_keys = $urandom_range(2, 20);
    end else begin
      len    = $urandom_range(200, 300);
      n_keys = $urandom_range(40, 96);
    end
    for (idx = 0; idx < n_keys; idx++) palette[idx] = rand_key();
    dom_pct = $urandom_range(0, 100);
    group_keys.delete();
    for (idx = 0; idx < len; idx++) begin
      if ($urandom_range(0, 99) < dom_pct) group_keys.push_back(palette[0]);
      else group_keys.push_back(palette[$urandom_range(0, n_keys - 1)]);
    end
    send_group_keys(rand_site());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values read back
  task automatic test_register_reset();
    read_check(REG_SHARE_THRESHOLD, THR_RESET);
    read_check(REG_FLANK_LENGTH, FLANK_RESET);
  endtask

  // field extremes, clamping, ties and single-word groups
  task automatic test_directed_groups();
    // single-word groups at both ends of key and site
    group_keys = {16'hFFFF};
    send_group_keys(31'h7FFF_FFFF);
    group_keys = {16'h0000};
    send_group_keys(31'd0);
    // site below the flank clamps the window start
    group_keys = {16'h1234, 16'h1234, 16'h1234};
    send_group_keys(31'd49);
    // zero threshold: every key passes, so only a lone key is assigned
    set_config(16'd0, 16'hFFFF);
    group_keys = {16'h00AA, 16'h00AA};
    send_group_keys(31'h7FFF_FFFF);
    group_keys = {16'h5555, 16'hAAAA};
    send_group_keys(31'd1000);
    // top threshold: only a key holding the whole group passes
    set_config(16'hFFFF, 16'd0);
    group_keys = {16'h8001};
    send_group_keys(31'h2AAA_5555);
    group_keys = {16'h0101, 16'h0101, 16'h0202};
    send_group_keys(31'h5555_2AAA);
    // half threshold: majority wins, an exact half does not
    set_config(16'd32768, 16'd7);
    group_keys = {16'h0777, 16'h0888, 16'h0777};
    send_group_keys(31'd7);
    group_keys = {16'h0777, 16'h0888};
    send_group_keys(31'd6);
  endtask

  // groups at and just past the word limit
  task automatic test_group_size_limit();
    int idx;
    group_keys.delete();
    for (idx = 0; idx < MAX_GROUP; idx++) group_keys.push_back((idx % 3 == 0) ? 16'h0043 : 16'h0042);
    send_group_keys(rand_site());
    // clear majority, but the extra words raise overflow and block the call
    group_keys.delete();
    for (idx = 0; idx < MAX_GROUP + 4; idx++) group_keys.push_back((idx % 4 == 0) ? 16'h0043 : 16'h0042);
    group_keys.push_back(16'h0044);
    send_group_keys(rand_site());
  endtask

  // groups at and just past the distinct key limit
  task automatic test_key_table_limit();
    int idx;
    group_keys.delete();
    for (idx = 0; idx < MAX_KEYS; idx++) group_keys.push_back(16'h4000 + KEY_W'(idx));
    send_group_keys(rand_site());
    // table overflows, then one key takes the majority of the counted words
    group_keys.delete();
    for (idx = 0; idx < MAX_KEYS + 2; idx++) group_keys.push_back(16'hC000 + KEY_W'(idx));
    for (idx = 0; idx < 100; idx++) group_keys.push_back(16'hC000);
    send_group_keys(rand_site());
    // next group starts clean
    group_keys = {16'h0099};
    send_group_keys(rand_site());
  endtask

  // receiver holds off for a long stretch while the sender keeps going
  task automatic test_result_backpressure();
    int grp;
    int idx;
    int len;
    steady_sender = 1'b1;
    hold_request  = HOLD_CYCLES;
    for (grp = 0; grp < 12; grp++) begin
      len = $urandom_range(1, 4);
      group_keys.delete();
      for (idx = 0; idx < len; idx++) group_keys.push_back(rand_key());
      send_group_keys(rand_site());
    end
    steady_sender = 1'b0;
    drain_calls();
  endtask

  // random groups across several register settings
  task automatic test_random_traffic();
    int phase;
    int target;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_config(THR_RESET, FLANK_RESET);
        1: set_config(16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'hFFFF);
        3: set_config(16'd32768, FLANK_W'($urandom));
        4: set_config(THR_W'($urandom), FLANK_W'($urandom));
        default: set_config(16'd43690, FLANK_W'($urandom_range(0, 300)));
      endcase
      // odd phases run without sender gaps
      steady_sender = phase[0];
      target = words_sent + RANDOM_WORDS / RANDOM_PHASES;
      while (words_sent < target) send_random_group();
    end
    steady_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // all inputs known from time zero
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.target_key    = '0;
    in_bus.site_position = '0;
    in_bus.group_end     = 1'b0;
    out_bus.ready        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_reset();
    test_directed_groups();
    test_group_size_limit();
    test_key_table_limit();
    test_result_backpressure();
    test_random_traffic();
    drain_calls();

    if (mismatch_count == 0 && expected_calls.size() == 0) begin
      $display("tb_group_dominant_key_detect passed");
    end else begin
      $display("tb_group_dominant_key_detect failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d calls outstanding", $time, expected_calls.size());
    $display("tb_group_dominant_key_detect failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gdk_pkg.sv
rtl/core/gdk_if.sv
rtl/core/gdk_cfg_regs.sv
rtl/core/gdk_entry_mem.sv
rtl/core/group_dominant_key_detect.sv
dv/tb_group_dominant_key_detect.sv
